@@ hw/rtl/dpt_pkg.sv @@
package dpt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int RES_SLOT_W  = 4;
  localparam logic [7:0] AGE_LIMIT_RESET = 8'd5;
  localparam logic [7:0] MISSES_MAX      = 8'hFF;

  localparam logic [1:0] OP_ANNOUNCE = 2'd0;
  localparam logic [1:0] OP_PING     = 2'd1;
  localparam logic [1:0] OP_LOOKUP   = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] mac;
    logic [31:0] ip_addr;
    logic [7:0]  dev_id;
  } item_t;

  typedef struct packed {
    logic                  found;
    logic [RES_SLOT_W-1:0] slot;
    logic                  dropped;
    logic [31:0]           ip_out;
    logic [7:0]            id_out;
  } result_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic        live;
    logic [1:0]  op;
    logic [47:0] mac;
    logic [31:0] ip_addr;
    logic [7:0]  dev_id;
    logic        hit;
    slot_idx_t   hit_idx;
    logic        free;
    slot_idx_t   free_idx;
    logic [31:0] ip_out;
    logic [7:0]  id_out;
  } token_t;

  typedef struct packed {
    logic fill;
    logic clear;
  } cell_cmd_t;

endpackage

@@ hw/rtl/dpt_cell.sv @@
module dpt_cell (
  input  logic              clk,
  input  logic              rst,
  input  dpt_pkg::slot_idx_t index,
  input  logic [7:0]        age_limit,
  input  dpt_pkg::token_t   tok_in,
  output dpt_pkg::token_t   tok_out,
  input  dpt_pkg::cell_cmd_t cmd,
  input  dpt_pkg::token_t   commit_tok
);
  import dpt_pkg::*;

  logic        slot_valid;
  logic [47:0] slot_mac;
  logic [31:0] slot_ip;
  logic [7:0]  slot_id;
  logic [7:0]  slot_misses;

  token_t tok_next;
  logic   match;
  logic   ping;
  logic   expire;

  assign match  = slot_valid && (slot_mac == tok_in.mac);
  assign ping   = tok_in.live && (tok_in.op == OP_PING) && slot_valid;
  assign expire = slot_misses > age_limit;

  always_comb begin
    tok_next = tok_in;
    // keep the first match only
    if (match && !tok_in.hit) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = index;
      tok_next.ip_out  = slot_ip;
      tok_next.id_out  = slot_id;
    end
    if (!slot_valid && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (cmd.fill) begin
      slot_valid <= 1'b1;
    end else if (ping && expire) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      slot_mac <= commit_tok.mac;
      slot_ip  <= commit_tok.ip_addr;
      slot_id  <= commit_tok.dev_id;
    end
    if (cmd.fill || cmd.clear) begin
      slot_misses <= 8'd0;
    end else if (ping && !expire && (slot_misses != MISSES_MAX)) begin
      slot_misses <= slot_misses + 8'd1;
    end
  end

endmodule

@@ hw/rtl/device_presence_table_core.sv @@
// done is registered from the live bit of the search token leaving the last cell.
// A new item is taken only while busy is low. The search token walks the chain
// of slot cells one cell a cycle; busy is high until it leaves the last cell.
// Results cannot be stalled: done flags each for exactly one cycle; result keeps it.
// Reset (rst, synchronous) empties the table and sets age_limit to 5.
module device_presence_table_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dpt_pkg::item_t   item,
  output logic             done,
  output dpt_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data
);
  import dpt_pkg::*;

  logic       [7:0] age_limit;
  token_t           tok_head;
  token_t           tok_chain [TABLE_SLOTS];
  token_t           tok_last;
  cell_cmd_t        cmd [TABLE_SLOTS];
  result_t          result_next;
  logic             accept;
  logic             is_announce;
  logic             is_lookup;

  assign accept   = start && !busy;
  assign tok_last = tok_chain[TABLE_SLOTS-1];

  always_comb begin
    tok_head          = '0;
    tok_head.live     = accept;
    tok_head.op       = item.op;
    tok_head.mac      = item.mac;
    tok_head.ip_addr  = item.ip_addr;
    tok_head.dev_id   = item.dev_id;
  end

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    always_comb begin
      cmd[i].clear = tok_last.live && is_announce && tok_last.hit
                     && (tok_last.hit_idx == slot_idx_t'(i));
      cmd[i].fill  = tok_last.live && is_announce && !tok_last.hit && tok_last.free
                     && (tok_last.free_idx == slot_idx_t'(i));
    end

    if (i == 0) begin : g_first
      dpt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .index      (slot_idx_t'(i)),
        .age_limit  (age_limit),
        .tok_in     (tok_head),
        .tok_out    (tok_chain[i]),
        .cmd        (cmd[i]),
        .commit_tok (tok_last)
      );
    end else begin : g_rest
      dpt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .index      (slot_idx_t'(i)),
        .age_limit  (age_limit),
        .tok_in     (tok_chain[i-1]),
        .tok_out    (tok_chain[i]),
        .cmd        (cmd[i]),
        .commit_tok (tok_last)
      );
    end
  end

  assign is_announce = tok_last.op == OP_ANNOUNCE;
  assign is_lookup   = tok_last.op == OP_LOOKUP;

  always_comb begin
    result_next = '0;
    if (is_announce) begin
      result_next.found = tok_last.hit;
      if (tok_last.hit) begin
        result_next.slot = RES_SLOT_W'(tok_last.hit_idx);
      end else if (tok_last.free) begin
        result_next.slot = RES_SLOT_W'(tok_last.free_idx);
      end else begin
        result_next.dropped = 1'b1;
      end
    end else if (is_lookup && tok_last.hit) begin
      result_next.found  = 1'b1;
      result_next.slot   = RES_SLOT_W'(tok_last.hit_idx);
      result_next.ip_out = tok_last.ip_out;
      result_next.id_out = tok_last.id_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_LIMIT_RESET;
    end else if (cfg_we) begin
      age_limit <= cfg_data;
    end
  end

  // hold busy until the token leaves the last cell and the table update lands
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tok_last.live;
      if (tok_last.live) begin
        busy <= 1'b0;
      end else if (accept) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_last.live) begin
      result <= result_next;
    end
  end

endmodule

@@ hw/rtl/dpt_checker.sv @@
module dpt_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input dpt_pkg::result_t result
);
  import dpt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a transfer in");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobed twice in a row");

  a_found_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.dropped))
    else $error("result both found and dropped");

  a_drop_slot: assert property (@(posedge clk) disable iff (rst)
    done && result.dropped |-> (result.slot == '0) && (result.ip_out == '0))
    else $error("dropped result carries slot or address");

endmodule

bind device_presence_table_core dpt_checker u_dpt_checker (.*);
